// File: rtl/pgn_pkg.sv
// Shared types and constants for the 2-D gradient noise core.
// Depends on nothing; every other file refers to it by scoped names.
package pgn_pkg;

	// Field widths fixed by the interface.
	localparam int CFG_W    = 7;
	localparam int COORD_W  = 32;
	localparam int FRAC_W   = 16;
	localparam int CELL_W   = 16;
	localparam int IDX_W    = 12;
	localparam int GRAD_W   = 16;
	localparam int NOISE_W  = 17;
	localparam int FADE_W   = 17;

	// Internal arithmetic widths.
	localparam int OFS_W    = FRAC_W + 2;
	localparam int DOT_W    = 34;
	localparam int DIFF_W   = DOT_W + 1;
	localparam int SPL_LO_W = 17;
	localparam int SPL_HI_W = DIFF_W - SPL_LO_W;
	localparam int PL_W     = FADE_W + SPL_LO_W;
	localparam int PH_W     = 2 * SPL_HI_W;
	localparam int ACC_W    = 54;
	localparam int RES_W    = ACC_W - 32;

	// Cell reduction: two bits of the cell index per pipeline stage.
	localparam int WRAP_BITS   = 2;
	localparam int WRAP_STAGES = CELL_W / WRAP_BITS;

	// Output queue.
	localparam int Q_DEPTH = 32;
	localparam int Q_AW    = 5;
	localparam int Q_CW    = 6;

	localparam int GRID_RESET = 16;
	localparam int N_CORNER   = 4;

	// Corner order of the four table reads.
	localparam int C00 = 0;
	localparam int C01 = 1;
	localparam int C10 = 2;
	localparam int C11 = 3;

	// Request codes.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_EVAL  = 1'b1;

	// Fade polynomial coefficients.
	localparam int FADE_C6  = 6;
	localparam int FADE_C15 = 15;
	localparam int FADE_C10 = 10;

	localparam logic signed [NOISE_W-1:0] NOISE_MAX = 17'h0FFFF;
	localparam logic signed [NOISE_W-1:0] NOISE_MIN = 17'h10000;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gy;
		logic signed [GRAD_W-1:0] gx;
	} grad_entry_t;

	typedef struct packed {
		logic valid;
		logic is_eval;
	} item_ctl_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} tbl_ctl_t;

endpackage

// File: rtl/pgn_cellwrap.sv
// Pipelined reduction of a signed lattice index modulo the grid size.
// Uses pgn_pkg for stage counts; each stage registers its partial remainder.
module pgn_cellwrap #(
	parameter int SW = 7,
	parameter int CW = 6
) (
	input  logic                         clk,
	input  logic [pgn_pkg::CELL_W-1:0]   coord_int,
	input  logic [SW-1:0]                size,
	output logic [CW-1:0]                wrapped
);

	localparam int NSTEP = pgn_pkg::WRAP_STAGES;

	// One remainder step: shift in one bit, subtract the size once if needed.
	function automatic logic [CW-1:0] rem_step(input logic [CW-1:0] r, input logic b,
			input logic [SW-1:0] s);
		logic [CW:0] t;
		t = {r, b};
		if (t >= (CW+1)'(s)) begin
			t = t - (CW+1)'(s);
		end
		return t[CW-1:0];
	endfunction

	logic [CW-1:0]               rem_q [NSTEP];
	logic [pgn_pkg::CELL_W-1:0]  val_q [NSTEP-1];
	logic [CW-1:0]               r_init;

	// The sign bit weighs -2^15, not 2^15, so a negative index starts from -1 mod size.
	assign r_init = coord_int[pgn_pkg::CELL_W-1] ? CW'(size - SW'(1)) : '0;

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		logic [CW-1:0]              r_src;
		logic [pgn_pkg::CELL_W-1:0] v_src;
		if (k == 0) begin : g_first
			assign r_src = r_init;
			assign v_src = coord_int;
		end else begin : g_next
			assign r_src = rem_q[k-1];
			assign v_src = val_q[k-1];
		end
		always_ff @(posedge clk) begin
			rem_q[k] <= rem_step(rem_step(r_src, v_src[pgn_pkg::CELL_W-1-2*k], size),
				v_src[pgn_pkg::CELL_W-2-2*k], size);
		end
		if (k < NSTEP-1) begin : g_carry
			always_ff @(posedge clk) begin
				val_q[k] <= v_src;
			end
		end
	end

	assign wrapped = rem_q[NSTEP-1];

endmodule

// File: rtl/pgn_fade.sv
// Four-stage pipeline for the quintic fade 6t^5-15t^4+10t^3, Q0.16 in and Q1.16 out.
// Uses pgn_pkg for widths and coefficients.
module pgn_fade (
	input  logic                        clk,
	input  logic [pgn_pkg::FRAC_W-1:0]  t,
	output logic [pgn_pkg::FADE_W-1:0]  fade
);

	logic [15:0] t_s1;
	logic [31:0] t2_s1;
	logic [31:0] t3_s2;
	logic [19:0] ph_s2;
	logic [51:0] prod_s3;
	logic [47:0] t3_full;
	logic [35:0] p_full;
	logic [52:0] rnd;

	always_ff @(posedge clk) begin
		t_s1  <= t;
		t2_s1 <= 32'(t) * 32'(t);
	end

	// p = 6t^2 - 15t*2^16 + 10*2^32 is always positive.
	always_comb begin
		t3_full = 48'(t2_s1) * 48'(t_s1);
		p_full  = 36'(pgn_pkg::FADE_C6) * 36'(t2_s1) + (36'(pgn_pkg::FADE_C10) << 32)
			- ((36'(pgn_pkg::FADE_C15) * 36'(t_s1)) << 16);
	end

	always_ff @(posedge clk) begin
		t3_s2 <= t3_full[47:16];
		ph_s2 <= p_full[35:16];
	end

	always_ff @(posedge clk) begin
		prod_s3 <= 52'(t3_s2) * 52'(ph_s2);
	end

	assign rnd = 53'(prod_s3) + (53'(1) << 31);

	always_ff @(posedge clk) begin
		fade <= rnd[32+pgn_pkg::FADE_W-1:32];
	end

endmodule

// File: rtl/pgn_table.sv
// Gradient table: four identical banks, each written on every table write
// and read at its own corner address. Uses pgn_pkg for entry and control types.
module pgn_table #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                   clk,
	input  pgn_pkg::tbl_ctl_t      ctl,
	input  logic [AW-1:0]          wr_addr,
	input  pgn_pkg::grad_entry_t   wr_data,
	input  logic [AW-1:0]          rd_addr [pgn_pkg::N_CORNER],
	output pgn_pkg::grad_entry_t   rd_data [pgn_pkg::N_CORNER]
);

	for (genvar b = 0; b < pgn_pkg::N_CORNER; b++) begin : g_bank
		pgn_pkg::grad_entry_t mem [DEPTH];
		pgn_pkg::grad_entry_t rd_q;

		always_ff @(posedge clk) begin
			if (ctl.wr_en) begin
				mem[wr_addr] <= wr_data;
			end
			if (ctl.rd_en) begin
				rd_q <= mem[rd_addr[b]];
			end
		end

		assign rd_data[b] = rd_q;
	end

endmodule

// File: rtl/pgn_blend.sv
// Corner dot products, fade-weighted x and y blends and output saturation.
// Uses pgn_pkg; takes the table read data through stages s12 to s17 and a registered result.
module pgn_blend (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [pgn_pkg::FRAC_W-1:0]          tx,
	input  logic [pgn_pkg::FRAC_W-1:0]          ty,
	input  pgn_pkg::grad_entry_t                ent [pgn_pkg::N_CORNER],
	input  logic [pgn_pkg::FADE_W-1:0]          u,
	input  logic [pgn_pkg::FADE_W-1:0]          v,
	output logic                                res_valid,
	output logic signed [pgn_pkg::NOISE_W-1:0]  res_value
);

	localparam int DOT_W  = pgn_pkg::DOT_W;
	localparam int DIFF_W = pgn_pkg::DIFF_W;
	localparam int LO_W   = pgn_pkg::SPL_LO_W;
	localparam int PL_W   = pgn_pkg::PL_W;
	localparam int PH_W   = pgn_pkg::PH_W;
	localparam int ACC_W  = pgn_pkg::ACC_W;
	localparam int OFS_W  = pgn_pkg::OFS_W;
	localparam logic signed [ACC_W-1:0] HALF16 = ACC_W'(1) <<< 16-1;
	localparam logic signed [ACC_W-1:0] HALF32 = ACC_W'(1) <<< 32-1;

	function automatic logic signed [DOT_W-1:0] dot(input pgn_pkg::grad_entry_t e,
			input logic signed [OFS_W-1:0] dx, input logic signed [OFS_W-1:0] dy);
		logic signed [DOT_W-1:0] px;
		logic signed [DOT_W-1:0] py;
		px = DOT_W'($signed(e.gx)) * DOT_W'(dx);
		py = DOT_W'($signed(e.gy)) * DOT_W'(dy);
		return px + py;
	endfunction

	function automatic logic [PL_W-1:0] mul_lo(input logic [pgn_pkg::FADE_W-1:0] w,
			input logic signed [DIFF_W-1:0] d);
		return PL_W'(w) * PL_W'(d[LO_W-1:0]);
	endfunction

	function automatic logic signed [PH_W-1:0] mul_hi(input logic [pgn_pkg::FADE_W-1:0] w,
			input logic signed [DIFF_W-1:0] d);
		return PH_W'($signed({1'b0, w})) * PH_W'($signed(d[DIFF_W-1:LO_W]));
	endfunction

	// (base << sh) + w * diff + half; the caller slices off the low bits. diff arrives split.
	function automatic logic signed [ACC_W-1:0] blend_acc(input logic signed [DOT_W-1:0] base,
			input logic signed [PH_W-1:0] ph, input logic [PL_W-1:0] pl, input int sh,
			input logic signed [ACC_W-1:0] half);
		return (ACC_W'(base) <<< sh) + (ACC_W'(ph) <<< LO_W)
			+ ACC_W'($signed({1'b0, pl})) + half;
	endfunction

	logic signed [OFS_W-1:0] dx0, dx1, dy0, dy1;
	logic signed [ACC_W-1:0] acc_x_lo, acc_x_hi, acc_y;
	logic signed [pgn_pkg::RES_W-1:0] res_wide;

	logic                    v_s12, v_s13, v_s14, v_s15, v_s16, v_s17;
	logic signed [DOT_W-1:0] g00_s12, g01_s12, g10_s12, g11_s12;
	logic signed [DOT_W-1:0] g00_s13, g01_s13;
	logic signed [DIFF_W-1:0] dlo_s13, dhi_s13;
	logic signed [DOT_W-1:0] g00_s14, g01_s14;
	logic signed [PH_W-1:0]  phl_s14, phh_s14;
	logic [PL_W-1:0]         pll_s14, plh_s14;
	logic [pgn_pkg::FADE_W-1:0] fv_s14, fv_s15, fv_s16;
	logic signed [DOT_W-1:0] lo_s15, hi_s15;
	logic signed [DOT_W-1:0] lo_s16;
	logic signed [DIFF_W-1:0] dy_s16;
	logic signed [DOT_W-1:0] lo_s17;
	logic signed [PH_W-1:0]  phy_s17;
	logic [PL_W-1:0]         ply_s17;

	// Offsets from the near and far corner along each axis, Q1.16.
	always_comb begin
		dx0 = $signed({2'b00, tx});
		dx1 = dx0 - OFS_W'(32'sd65536);
		dy0 = $signed({2'b00, ty});
		dy1 = dy0 - OFS_W'(32'sd65536);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
			v_s17 <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			v_s12 <= in_valid;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
			res_valid <= v_s17;
		end
	end

	always_comb begin
		acc_x_lo = blend_acc(g00_s14, phl_s14, pll_s14, 16, HALF16);
		acc_x_hi = blend_acc(g01_s14, phh_s14, plh_s14, 16, HALF16);
		acc_y    = blend_acc(lo_s17, phy_s17, ply_s17, 16, HALF32);
		res_wide = $signed(acc_y[ACC_W-1:32]);
	end

	always_ff @(posedge clk) begin
		// Corner dot products.
		g00_s12 <= dot(ent[pgn_pkg::C00], dx0, dy0);
		g01_s12 <= dot(ent[pgn_pkg::C01], dx0, dy1);
		g10_s12 <= dot(ent[pgn_pkg::C10], dx1, dy0);
		g11_s12 <= dot(ent[pgn_pkg::C11], dx1, dy1);
		// Differences along x.
		g00_s13 <= g00_s12;
		g01_s13 <= g01_s12;
		dlo_s13 <= DIFF_W'(g10_s12) - DIFF_W'(g00_s12);
		dhi_s13 <= DIFF_W'(g11_s12) - DIFF_W'(g01_s12);
		// x weights; the y weight waits until the y blend.
		g00_s14 <= g00_s13;
		g01_s14 <= g01_s13;
		pll_s14 <= mul_lo(u, dlo_s13);
		phl_s14 <= mul_hi(u, dlo_s13);
		plh_s14 <= mul_lo(u, dhi_s13);
		phh_s14 <= mul_hi(u, dhi_s13);
		fv_s14  <= v;
		fv_s15  <= fv_s14;
		fv_s16  <= fv_s15;
		lo_s15  <= $signed(acc_x_lo[DOT_W+15:16]);
		hi_s15  <= $signed(acc_x_hi[DOT_W+15:16]);
		// Difference along y, then its weight.
		lo_s16  <= lo_s15;
		dy_s16  <= DIFF_W'(hi_s15) - DIFF_W'(lo_s15);
		lo_s17  <= lo_s16;
		ply_s17 <= mul_lo(fv_s16, dy_s16);
		phy_s17 <= mul_hi(fv_s16, dy_s16);
		// Saturate to the Q2.14 output range.
		if (res_wide > pgn_pkg::RES_W'(pgn_pkg::NOISE_MAX)) begin
			res_value <= pgn_pkg::NOISE_MAX;
		end else if (res_wide < pgn_pkg::RES_W'(pgn_pkg::NOISE_MIN)) begin
			res_value <= pgn_pkg::NOISE_MIN;
		end else begin
			res_value <= res_wide[pgn_pkg::NOISE_W-1:0];
		end
	end

endmodule

// File: rtl/pgn_outq.sv
// Output queue that holds finished noise items until the consumer takes them.
// Uses pgn_pkg for its depth and the item width.
module pgn_outq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic signed [pgn_pkg::NOISE_W-1:0]  push_data,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic signed [pgn_pkg::NOISE_W-1:0]  out_data
);

	logic signed [pgn_pkg::NOISE_W-1:0] slot_q [pgn_pkg::Q_DEPTH];
	logic [pgn_pkg::Q_AW-1:0] wp_q;
	logic [pgn_pkg::Q_AW-1:0] rp_q;
	logic [pgn_pkg::Q_CW-1:0] fill_q;
	logic                     pop;

	assign out_valid = (fill_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + pgn_pkg::Q_AW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + pgn_pkg::Q_AW'(1);
			end
			fill_q <= fill_q + pgn_pkg::Q_CW'(push) - pgn_pkg::Q_CW'(pop);
		end
	end

endmodule

// File: rtl/perlin_gradient_noise_2d_core.sv
// 2-D gradient noise core: an accepted evaluate item reaches out_valid through the stages below.
// Throughput is one item per cycle while in_ready is high, writes and evaluates alike; the
// four corner reads each have a bank of their own and the cell reduction is fully pipelined.
// in_ready falls only while 32 accepted evaluates still wait for their results to be taken.
// Reset (arst_n low) clears all valid flags, the queue and credits and sets the grid size
// to 16; the gradient table is not cleared and must be written first.
module perlin_gradient_noise_2d_core #(
	parameter int MAX_GRID = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write channel: grid size.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pgn_pkg::CFG_W-1:0]           cfg_data,
	// Request channel.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic signed [pgn_pkg::COORD_W-1:0]  x_coord,
	input  logic signed [pgn_pkg::COORD_W-1:0]  y_coord,
	input  logic [pgn_pkg::IDX_W-1:0]           entry_index,
	input  logic signed [pgn_pkg::GRAD_W-1:0]   grad_x,
	input  logic signed [pgn_pkg::GRAD_W-1:0]   grad_y,
	// Result channel.
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pgn_pkg::NOISE_W-1:0]  noise_value
);

	// Table geometry and index widths follow from the largest grid.
	localparam int DEPTH    = MAX_GRID * MAX_GRID;
	localparam int AW       = $clog2(DEPTH);
	localparam int CW       = $clog2(MAX_GRID);
	localparam int SW       = $clog2(MAX_GRID + 1);
	localparam int CMP_W    = ((SW > pgn_pkg::CFG_W) ? SW : pgn_pkg::CFG_W) + 1;
	localparam int IW       = ((AW > pgn_pkg::IDX_W) ? AW : pgn_pkg::IDX_W) + 1;
	localparam int SIZE_RST = (pgn_pkg::GRID_RESET > MAX_GRID) ? MAX_GRID : pgn_pkg::GRID_RESET;
	localparam int LINE     = pgn_pkg::WRAP_STAGES;
	localparam int FW       = pgn_pkg::FRAC_W;

	// Grid size register, clamped to 1..MAX_GRID when written. The user must write it only
	// while nothing is in flight; the block does not enforce this, and the pipeline reads it directly.
	logic [SW-1:0]    size_q;
	logic [CMP_W-1:0] cfg_ext;
	logic [SW-1:0]    size_d;

	assign cfg_ready = 1'b1;
	assign cfg_ext   = CMP_W'(cfg_data);

	always_comb begin
		priority if (cfg_ext == '0) begin
			size_d = SW'(1);
		end else if (cfg_ext > CMP_W'(MAX_GRID)) begin
			size_d = SW'(MAX_GRID);
		end else begin
			size_d = SW'(cfg_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SW'(SIZE_RST);
		end else if (cfg_valid && cfg_ready) begin
			size_q <= size_d;
		end
	end

	// Credits: every accepted evaluate holds one queue slot from acceptance
	// until its result is taken, so the pipeline itself never stalls and the
	// queue can never overflow.
	logic [pgn_pkg::Q_CW-1:0] credit_q;
	logic in_acc;
	logic eval_acc;
	logic out_acc;

	assign in_ready = (credit_q < pgn_pkg::Q_CW'(pgn_pkg::Q_DEPTH));
	assign in_acc   = in_valid && in_ready;
	assign eval_acc = in_acc && (req_type == pgn_pkg::REQ_EVAL);
	assign out_acc  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + pgn_pkg::Q_CW'(eval_acc) - pgn_pkg::Q_CW'(out_acc);
		end
	end

	// Stages 1 to 8: the cell index of each axis is reduced modulo the grid
	// size two bits per stage; the rest of the item rides along beside it.
	// A write item carries its table address and entry down the same line so
	// that it lands in the table in order with the evaluates around it.
	pgn_pkg::item_ctl_t   ctl_q  [LINE];
	logic [FW-1:0]        tx_q   [LINE];
	logic [FW-1:0]        ty_q   [LINE];
	logic [AW-1:0]        widx_q [LINE];
	logic                 wok_q  [LINE];
	pgn_pkg::grad_entry_t wdat_q [LINE];
	pgn_pkg::item_ctl_t   ctl_in;
	logic [CW-1:0]        cx_w;
	logic [CW-1:0]        cy_w;

	assign ctl_in = '{valid: in_acc, is_eval: (req_type == pgn_pkg::REQ_EVAL)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LINE; k++) begin
				ctl_q[k] <= '0;
			end
		end else begin
			ctl_q[0] <= ctl_in;
			for (int k = 1; k < LINE; k++) begin
				ctl_q[k] <= ctl_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		tx_q[0]   <= x_coord[FW-1:0];
		ty_q[0]   <= y_coord[FW-1:0];
		widx_q[0] <= AW'(entry_index);
		// Indices beyond the table are dropped.
		wok_q[0]  <= (IW'(entry_index) < IW'(DEPTH));
		wdat_q[0] <= '{gy: grad_y, gx: grad_x};
		for (int k = 1; k < LINE; k++) begin
			tx_q[k]   <= tx_q[k-1];
			ty_q[k]   <= ty_q[k-1];
			widx_q[k] <= widx_q[k-1];
			wok_q[k]  <= wok_q[k-1];
			wdat_q[k] <= wdat_q[k-1];
		end
	end

	pgn_cellwrap #(.SW(SW), .CW(CW)) u_wrap_x (
		.clk       (clk),
		.coord_int (x_coord[pgn_pkg::COORD_W-1:FW]),
		.size      (size_q),
		.wrapped   (cx_w)
	);

	pgn_cellwrap #(.SW(SW), .CW(CW)) u_wrap_y (
		.clk       (clk),
		.coord_int (y_coord[pgn_pkg::COORD_W-1:FW]),
		.size      (size_q),
		.wrapped   (cy_w)
	);

	// Stage 9: neighbor cells, wrapping from size-1 back to 0.
	pgn_pkg::item_ctl_t   ctl_s9;
	logic [CW-1:0]        cx_s9, cy_s9, nx_s9, ny_s9;
	logic [FW-1:0]        tx_s9, ty_s9;
	logic [AW-1:0]        widx_s9;
	logic                 wok_s9;
	pgn_pkg::grad_entry_t wdat_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s9 <= '0;
		end else begin
			ctl_s9 <= ctl_q[LINE-1];
		end
	end

	always_ff @(posedge clk) begin
		cx_s9   <= cx_w;
		cy_s9   <= cy_w;
		nx_s9   <= (SW'(cx_w) + SW'(1) == size_q) ? '0 : CW'(SW'(cx_w) + SW'(1));
		ny_s9   <= (SW'(cy_w) + SW'(1) == size_q) ? '0 : CW'(SW'(cy_w) + SW'(1));
		tx_s9   <= tx_q[LINE-1];
		ty_s9   <= ty_q[LINE-1];
		widx_s9 <= widx_q[LINE-1];
		wok_s9  <= wok_q[LINE-1];
		wdat_s9 <= wdat_q[LINE-1];
	end

	// Stage 10: table addresses, column plus row times size. Only one item
	// occupies this stage at a time and the table is read or written only
	// here, so a read always sees every earlier write and never a later one.
	pgn_pkg::tbl_ctl_t    tbl_s10;
	logic [AW-1:0]        raddr_s10 [pgn_pkg::N_CORNER];
	logic [AW-1:0]        waddr_s10;
	pgn_pkg::grad_entry_t wdat_s10;
	logic [FW-1:0]        tx_s10, ty_s10;
	logic [AW-1:0]        row0, row1;

	assign row0 = AW'(cy_s9) * AW'(size_q);
	assign row1 = AW'(ny_s9) * AW'(size_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_s10 <= '0;
		end else begin
			tbl_s10 <= '{wr_en: ctl_s9.valid && !ctl_s9.is_eval && wok_s9,
				rd_en: ctl_s9.valid && ctl_s9.is_eval};
		end
	end

	always_ff @(posedge clk) begin
		raddr_s10[pgn_pkg::C00] <= AW'(cx_s9) + row0;
		raddr_s10[pgn_pkg::C01] <= AW'(cx_s9) + row1;
		raddr_s10[pgn_pkg::C10] <= AW'(nx_s9) + row0;
		raddr_s10[pgn_pkg::C11] <= AW'(nx_s9) + row1;
		waddr_s10 <= widx_s9;
		wdat_s10  <= wdat_s9;
		tx_s10    <= tx_s9;
		ty_s10    <= ty_s9;
	end

	// Stage 11: corner gradients come out of the four banks.
	pgn_pkg::grad_entry_t ent_s11 [pgn_pkg::N_CORNER];
	logic                 eval_s11;
	logic [FW-1:0]        tx_s11, ty_s11;

	pgn_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
		.clk     (clk),
		.ctl     (tbl_s10),
		.wr_addr (waddr_s10),
		.wr_data (wdat_s10),
		.rd_addr (raddr_s10),
		.rd_data (ent_s11)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s11 <= 1'b0;
		end else begin
			eval_s11 <= tbl_s10.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		tx_s11 <= tx_s10;
		ty_s11 <= ty_s10;
	end

	// Fade weights start at stage 9 and are ready at stage 13, when the
	// blend needs the x weight.
	logic [pgn_pkg::FADE_W-1:0] u_s13;
	logic [pgn_pkg::FADE_W-1:0] v_s13;

	pgn_fade u_fade_x (
		.clk  (clk),
		.t    (tx_s9),
		.fade (u_s13)
	);

	pgn_fade u_fade_y (
		.clk  (clk),
		.t    (ty_s9),
		.fade (v_s13)
	);

	// Stages 12 to 18: dot products, x blend, y blend, saturation.
	logic                                res_valid;
	logic signed [pgn_pkg::NOISE_W-1:0]  res_value;

	pgn_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (eval_s11),
		.tx        (tx_s11),
		.ty        (ty_s11),
		.ent       (ent_s11),
		.u         (u_s13),
		.v         (v_s13),
		.res_valid (res_valid),
		.res_value (res_value)
	);

	pgn_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res_value),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (noise_value)
	);

`ifndef SYNTH
	// Credits never exceed the queue depth.
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= pgn_pkg::Q_CW'(pgn_pkg::Q_DEPTH))
		else $error("credit count above queue depth");

	// A waiting result always holds a credit.
	a_out_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> credit_q != '0)
		else $error("result presented without a credit");

	// A finished result always belongs to an outstanding credit.
	a_res_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> credit_q != '0)
		else $error("result finished without a credit");

	// The table stage holds one item, so it never reads and writes at once.
	a_tbl_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(tbl_s10.wr_en && tbl_s10.rd_en))
		else $error("table read and write in the same cycle");
`endif

endmodule
